@@ rtl/core/lpfd_pkg.sv @@
// shared types and constants for the length-prefixed frame decoder
package lpfd_pkg;

	// stored frame positions, header included
	localparam int FRAME_BYTES = 16;

	// decoded positions
	localparam int SYS_POS = 1;
	localparam int CMD_POS = 2;
	localparam int BODY_FIRST = 3;
	localparam int BODY_BYTES = 12;

	// system and command codes
	localparam logic [7:0] SYS_VIDEO = 8'd2;
	localparam logic [7:0] SYS_BUS = 8'd1;
	localparam logic [7:0] CMD_TIMING = 8'd3;
	localparam logic [7:0] CMD_FORMAT = 8'd1;
	localparam logic [7:0] CMD_RX_SETUP = 8'd1;

	// frames waiting between the assembler and the decoder
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_VIDEO   = 2'd1,
		KIND_SDI     = 2'd2,
		KIND_BUS     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                           kind;
		logic [BODY_BYTES-1:0][7:0]      body;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ rtl/core/lpfd_front.sv @@
// frame assembler: counts bytes, stores the frame and classifies it on completion
module lpfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      rx_byte,
	input  lpfd_pkg::q_stat_t q_stat,
	output logic            full,
	output logic            q_push,
	output lpfd_pkg::entry_t q_entry
);
	import lpfd_pkg::*;

	logic [7:0] count_q;
	logic [7:0] length_q;
	logic [7:0] store_q [FRAME_BYTES];
	logic [7:0] store_nx [FRAME_BYTES];
	logic       accept;
	logic       header;
	logic [7:0] count_inc;
	logic       done;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;
	assign header = (count_q == 8'd0);
	assign count_inc = count_q + 8'd1;

	// a header byte of one closes the frame at once
	assign done = header ? (rx_byte == 8'd1) : (count_inc == length_q);

	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			store_nx[i] = store_q[i];
			if (header) begin
				store_nx[i] = (i == 0) ? rx_byte : 8'd0;
			end else if (count_q == 8'(i)) begin
				store_nx[i] = rx_byte;
			end
		end
	end

	always_comb begin
		logic [7:0] sys;
		logic [7:0] cmd;
		sys = store_nx[SYS_POS];
		cmd = store_nx[CMD_POS];
		priority if (sys == SYS_VIDEO && cmd == CMD_TIMING) begin
			q_entry.kind = KIND_VIDEO;
		end else if (sys == SYS_VIDEO && cmd == CMD_FORMAT) begin
			q_entry.kind = KIND_SDI;
		end else if (sys == SYS_BUS && cmd == CMD_RX_SETUP) begin
			q_entry.kind = KIND_BUS;
		end else begin
			q_entry.kind = KIND_UNKNOWN;
		end
		for (int j = 0; j < BODY_BYTES; j++) begin
			q_entry.body[j] = store_nx[BODY_FIRST + j];
		end
	end

	assign q_push = accept && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'd0;
			length_q <= 8'd0;
		end else if (accept) begin
			if (header) begin
				length_q <= rx_byte;
			end
			// length zero wraps the count through 255 to a 256-byte frame
			count_q <= done ? 8'd0 : (header ? 8'd1 : count_inc);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= store_nx;
		end
	end

endmodule

@@ rtl/core/lpfd_queue.sv @@
// short queue of classified frames between assembler and decoder
module lpfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  lpfd_pkg::entry_t wr_entry,
	input  logic             rd_en,
	output lpfd_pkg::entry_t rd_entry,
	output lpfd_pkg::q_stat_t stat
);
	import lpfd_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && !stat.empty;
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

@@ rtl/core/lpfd_back.sv @@
// field extraction and result output register
module lpfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lpfd_pkg::entry_t  q_entry,
	input  lpfd_pkg::q_stat_t q_stat,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        frame_kind,
	output logic [15:0]       word_a,
	output logic [15:0]       word_b,
	output logic [15:0]       word_c,
	output logic [15:0]       word_d,
	output logic [15:0]       word_e,
	output logic [15:0]       word_f
);
	import lpfd_pkg::*;

	logic         valid_q;
	kind_t        kind_q;
	logic [15:0]  words_q [6];
	logic [15:0]  words_nx [6];
	logic         load;

	// refill when the output is free or being taken this cycle
	assign load  = !q_stat.empty && (!valid_q || pop);
	assign q_pop = load;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			words_nx[k] = 16'd0;
		end
		unique case (q_entry.kind)
			KIND_VIDEO: begin
				for (int k = 0; k < 6; k++) begin
					words_nx[k] = {q_entry.body[2*k], q_entry.body[2*k+1]};
				end
			end
			KIND_SDI: begin
				words_nx[0] = {8'd0, q_entry.body[0]};
				words_nx[1] = {8'd0, q_entry.body[1]};
				words_nx[2] = {q_entry.body[2], q_entry.body[3]};
				words_nx[3] = {q_entry.body[4], q_entry.body[5]};
			end
			KIND_BUS: begin
				for (int k = 0; k < 6; k++) begin
					words_nx[k] = {8'd0, q_entry.body[k]};
				end
			end
			KIND_UNKNOWN: begin
				words_nx[0] = 16'd0;
			end
			default: begin
				words_nx[0] = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= q_entry.kind;
			words_q <= words_nx;
		end
	end

	assign empty      = !valid_q;
	assign frame_kind = kind_q;
	assign word_a     = words_q[0];
	assign word_b     = words_q[1];
	assign word_c     = words_q[2];
	assign word_d     = words_q[3];
	assign word_e     = words_q[4];
	assign word_f     = words_q[5];

endmodule

@@ rtl/core/length_prefixed_frame_decoder.sv @@
// top level of the length-prefixed frame decoder
//
// input side: one link byte per request on rx_byte, taken when push is high
// and full is low. the first byte of a frame is its total length, header
// included; a length of zero means 256 bytes. the next bytes are the
// system code, command code and body, until the count reaches the length.
// result side: one request per completed frame. while empty is low the
// oldest result sits on frame_kind and word_a..word_f; pop takes it.
// throughput: one byte per cycle, sustained, with the result side popping.
// the last byte of a frame is written into the frame queue; from there
// the result is loaded into the output register once that is free or
// being popped.
// a queue of two frames plus the output register lets the receiver stall;
// full rises only when all three hold results, and then no byte is taken.
// reset: the frame queue and the output register empty, the byte count at
// zero, so the next byte taken is read as a header.
module length_prefixed_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  frame_kind,
	output logic [15:0] word_a,
	output logic [15:0] word_b,
	output logic [15:0] word_c,
	output logic [15:0] word_d,
	output logic [15:0] word_e,
	output logic [15:0] word_f
);
	import lpfd_pkg::*;

	q_stat_t q_stat;
	entry_t  wr_entry;
	entry_t  rd_entry;
	logic    q_push;
	logic    q_pop;

	lpfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.q_stat  (q_stat),
		.full    (full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	lpfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.stat     (q_stat)
	);

	lpfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_entry    (rd_entry),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.frame_kind (frame_kind),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.word_d     (word_d),
		.word_e     (word_e),
		.word_f     (word_f)
	);

endmodule

@@ rtl/core/lpfd_checker.sv @@
// port-level checks for the frame decoder, bound to the top level
module lpfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  frame_kind,
	input logic [15:0] word_a,
	input logic [15:0] word_b,
	input logic [15:0] word_c,
	input logic [15:0] word_d,
	input logic [15:0] word_e,
	input logic [15:0] word_f
);
	import lpfd_pkg::*;

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_kind) && $stable(word_a)
			&& $stable(word_f))
		else $error("result changed while stalled");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_kind == KIND_UNKNOWN |-> word_a == 16'd0 && word_b == 16'd0
			&& word_c == 16'd0 && word_d == 16'd0 && word_e == 16'd0 && word_f == 16'd0)
		else $error("unknown frame with nonzero words");

	a_sdi_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_kind == KIND_SDI |-> word_a[15:8] == 8'd0
			&& word_b[15:8] == 8'd0 && word_e == 16'd0 && word_f == 16'd0)
		else $error("sdi result out of shape");

	a_bus_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_kind == KIND_BUS |-> word_a[15:8] == 8'd0
			&& word_b[15:8] == 8'd0 && word_c[15:8] == 8'd0 && word_d[15:8] == 8'd0
			&& word_e[15:8] == 8'd0 && word_f[15:8] == 8'd0)
		else $error("bus result wider than a byte");

	// the queue can only fill while results are waiting
	a_full_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full with no result waiting");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (.*);

@@ verif/length_prefixed_frame_decoder_test.sv @@
`timescale 1ns / 1ps
// testbench for the length-prefixed frame decoder: random frames, queue stalls, decode checks
module length_prefixed_frame_decoder_test;
	import lpfd_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic [15:0] e;
		logic [15:0] f;
	} frame_result_t;

	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	class frame_tracker;
		logic [7:0]    seen;
		logic [7:0]    frame_len;
		logic [7:0]    store [FRAME_BYTES];
		frame_result_t decoded_q [$];
		int            mismatches;

		function new();
			seen = '0;
			frame_len = '0;
			foreach (store[i]) store[i] = '0;
			mismatches = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function logic [15:0] pair_at(int pos);
			return {store[pos], store[pos + 1]};
		endfunction

		function frame_result_t decode();
			frame_result_t r;
			logic [7:0] sys;
			logic [7:0] cmd;
			r = '0;
			sys = store[SYS_POS];
			cmd = store[CMD_POS];
			if (sys == SYS_VIDEO && cmd == CMD_TIMING) begin
				r.kind = KIND_VIDEO;
				r.a = pair_at(3);
				r.b = pair_at(5);
				r.c = pair_at(7);
				r.d = pair_at(9);
				r.e = pair_at(11);
				r.f = pair_at(13);
			end else if (sys == SYS_VIDEO && cmd == CMD_FORMAT) begin
				r.kind = KIND_SDI;
				r.a = {8'd0, store[3]};
				r.b = {8'd0, store[4]};
				r.c = pair_at(5);
				r.d = pair_at(7);
			end else if (sys == SYS_BUS && cmd == CMD_RX_SETUP) begin
				r.kind = KIND_BUS;
				r.a = {8'd0, store[3]};
				r.b = {8'd0, store[4]};
				r.c = {8'd0, store[5]};
				r.d = {8'd0, store[6]};
				r.e = {8'd0, store[7]};
				r.f = {8'd0, store[8]};
			end else begin
				r.kind = KIND_UNKNOWN;
			end
			return r;
		endfunction

		// header clears the store; the 8-bit count wraps, so length zero is 256 bytes
		function void take_byte(logic [7:0] rx);
			if (seen == 0) begin
				foreach (store[i]) store[i] = '0;
				store[0] = rx;
				frame_len = rx;
				seen = 8'd1;
			end else begin
				if (seen < FRAME_BYTES)
					store[seen] = rx;
				seen = seen + 8'd1;
			end
			if (seen == frame_len) begin
				seen = '0;
				decoded_q.push_back(decode());
			end
		endfunction

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task match_result(frame_result_t got);
			frame_result_t want;
			if (decoded_q.size() == 0) begin
				report("result popped with no frame pending");
			end else begin
				want = decoded_q.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("frame_kind got %0d want %0d", got.kind, want.kind));
				check_field("word_a", got.a, want.a);
				check_field("word_b", got.b, want.b);
				check_field("word_c", got.c, want.c);
				check_field("word_d", got.d, want.d);
				check_field("word_e", got.e, want.e);
				check_field("word_f", got.f, want.f);
			end
		endtask

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  frame_kind;
	logic [15:0] word_a;
	logic [15:0] word_b;
	logic [15:0] word_c;
	logic [15:0] word_d;
	logic [15:0] word_e;
	logic [15:0] word_f;

	frame_tracker book = new();
	int           bytes_sent = 0;
	bit           quiet = 1'b0;
	int           hold_len = 0;

	length_prefixed_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.frame_kind(frame_kind),
		.word_a(word_a),
		.word_b(word_b),
		.word_c(word_c),
		.word_d(word_d),
		.word_e(word_e),
		.word_f(word_f)
	);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		quiet = (bytes_sent >= 500 && bytes_sent < 720);
		if (!quiet && $urandom_range(99) < 10) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		book.take_byte(b);
		bytes_sent++;
	endtask

	// n is the total length, header included; 256 goes out as header zero
	task automatic send_frame(input int n, input logic [7:0] sys, input logic [7:0] cmd,
			input fill_t fill);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				b = n[7:0];
			else if (i == SYS_POS)
				b = sys;
			else if (i == CMD_POS)
				b = cmd;
			else if (fill == FILL_ONES)
				b = 8'hff;
			else if (fill == FILL_ZEROS)
				b = 8'h00;
			else
				b = 8'($urandom);
			send_byte(b);
		end
	endtask

	// result side: check at the accepting edge, then pick pop for the next cycle
	initial begin
		frame_result_t got;
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got.kind = kind_t'(frame_kind);
				got.a = word_a;
				got.b = word_b;
				got.c = word_c;
				got.d = word_d;
				got.e = word_e;
				got.f = word_f;
				book.match_result(got);
			end
			if (hold_len != 0 && !hold_done) begin
				hold_left = hold_len;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(99) < 10) begin
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int n;
		int pick;
		int frame_no;
		logic [7:0] s;
		logic [7:0] c;
		fill_t fill;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length one completes on its header, short frames read zeros
		send_frame(1, 8'd0, 8'd0, FILL_RANDOM);
		send_frame(2, SYS_VIDEO, 8'd0, FILL_RANDOM);
		send_frame(3, SYS_VIDEO, CMD_TIMING, FILL_RANDOM);
		send_frame(15, SYS_VIDEO, CMD_TIMING, FILL_ONES);
		send_frame(9, SYS_VIDEO, CMD_FORMAT, FILL_RANDOM);
		send_frame(9, SYS_BUS, CMD_RX_SETUP, FILL_ZEROS);
		send_frame(4, 8'hff, 8'hff, FILL_RANDOM);

		// receiver holds off while frames keep coming, so the block fills up
		hold_len = 400;
		frame_no = 0;
		while (bytes_sent < 1050) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				s = SYS_VIDEO; c = CMD_TIMING; n = 15;
			end else if (pick < 50) begin
				s = SYS_VIDEO; c = CMD_FORMAT; n = 9;
			end else if (pick < 70) begin
				s = SYS_BUS; c = CMD_RX_SETUP; n = 9;
			end else if (pick < 85) begin
				s = 8'($urandom_range(0, 3)); c = 8'($urandom_range(0, 4));
				n = $urandom_range(3, 16);
			end else begin
				s = 8'($urandom); c = 8'($urandom); n = $urandom_range(3, 16);
			end
			pick = $urandom_range(99);
			if (pick < 15)
				n = $urandom_range(1, 16);
			else if (pick < 20)
				n = $urandom_range(17, 64);
			if (frame_no == 20)
				n = 256;
			fill = ($urandom_range(99) < 5) ? FILL_ONES : FILL_RANDOM;
			send_frame(n, s, c, fill);
			frame_no++;
		end
		push <= 1'b0;

		while (book.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (book.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
